[design/zcs_pkg.sv]
package zcs_pkg;

  localparam int unsigned ZCS_MAX_BASINS_DEF = 4096;

  localparam int unsigned ZCS_CNT_W   = 32;
  localparam int unsigned ZCS_SUM_W   = 64;
  localparam int unsigned ZCS_ENTRY_W = ZCS_CNT_W + ZCS_SUM_W;
  localparam int unsigned ZCS_NB_W    = 13;
  localparam int unsigned ZCS_BASIN_W = 12;

  typedef logic [1:0] zcs_kind_t;
  typedef logic [2:0] zcs_status_t;

  localparam zcs_kind_t KIND_ACCUM   = 2'd0;
  localparam zcs_kind_t KIND_READOUT = 2'd1;
  localparam zcs_kind_t KIND_CLEAR   = 2'd2;
  localparam zcs_kind_t KIND_UNUSED  = 2'd3;

  localparam zcs_status_t STAT_ACCUM   = 3'd0;
  localparam zcs_status_t STAT_SKIP    = 3'd1;
  localparam zcs_status_t STAT_OVER    = 3'd2;
  localparam zcs_status_t STAT_READOUT = 3'd3;
  localparam zcs_status_t STAT_CLEARED = 3'd4;

  typedef struct packed {
    zcs_kind_t                kind;
    logic signed [31:0]       basin_label;
    logic signed [31:0]       cell_value;
    logic [ZCS_BASIN_W-1:0]   basin_index;
  } zcs_in_t;

  typedef struct packed {
    zcs_status_t              status;
    logic [ZCS_BASIN_W-1:0]   result_basin;
    logic [ZCS_CNT_W-1:0]     cell_count;
    logic signed [ZCS_SUM_W-1:0] value_sum;
  } zcs_out_t;

endpackage

[design/zcs_ram.sv]
module zcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

[design/zonal_count_and_sum_top.sv]
// A transaction is registered into the read stage as its memory read is issued; the modify
// stage then writes back and loads the result register, which drives the result strobe.
// One transaction per cycle while busy is low; the write-back stage forwards to the read stage
// when consecutive transactions hit the same basin entry.
// Reset: synchronous; the entry memory is then swept to zero entry by entry, with busy high.
// The receiver cannot stall: every result is shown for exactly one cycle.
module zonal_count_and_sum_top
  import zcs_pkg::*;
#(
  parameter int unsigned MAX_BASINS = ZCS_MAX_BASINS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  zcs_in_t             in_data,
  output logic                out_valid,
  output zcs_out_t            out_data,
  input  logic                cfg_we,
  input  logic [ZCS_NB_W-1:0] cfg_wdata
);

  localparam int unsigned AW = (MAX_BASINS > 1) ? $clog2(MAX_BASINS) : 1;
  localparam logic [31:0] MAX_B32 = 32'(MAX_BASINS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BASINS - 1);

  logic [ZCS_NB_W-1:0] num_basins_r;
  logic                clearing_r;
  logic [AW-1:0]       clr_addr_r;

  logic                s1_valid_r;
  zcs_status_t         s1_status_r;
  logic [ZCS_BASIN_W-1:0] s1_basin_r;
  logic [AW-1:0]       s1_addr_r;
  logic signed [31:0]  s1_value_r;

  logic                fwd_valid_r;
  logic [AW-1:0]       fwd_addr_r;
  logic [ZCS_ENTRY_W-1:0] fwd_data_r;

  logic                out_valid_r;
  zcs_out_t            out_r;

  logic                accept;
  logic [31:0]         lim;
  logic                lbl_neg;
  logic [29:0]         idx;
  logic                acc_over;
  logic                ix_over;
  zcs_status_t         s0_status;
  logic [ZCS_BASIN_W-1:0] s0_basin;
  logic [AW-1:0]       s0_addr;

  logic [ZCS_ENTRY_W-1:0] ram_rdata;
  logic [ZCS_ENTRY_W-1:0] cur;
  logic [ZCS_CNT_W-1:0]   cur_cnt;
  logic [ZCS_SUM_W-1:0]   cur_sum;
  logic [ZCS_CNT_W-1:0]   new_cnt;
  logic [ZCS_SUM_W-1:0]   new_sum;
  logic                   s2_we;
  zcs_out_t               s2_out;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [ZCS_ENTRY_W-1:0] ram_wdata;

  assign busy   = clearing_r;
  assign accept = start && !busy;

  // decode and range check on the way in
  always_comb begin
    lim = ({19'd0, num_basins_r} < MAX_B32) ? {19'd0, num_basins_r} : MAX_B32;
    // label / 2 - 1 is negative for every label below two
    lbl_neg  = (in_data.basin_label < 32'sd2);
    idx      = in_data.basin_label[30:1] - 30'd1;
    acc_over = ({2'd0, idx} >= lim);
    ix_over  = ({20'd0, in_data.basin_index} >= lim);
    s0_status = STAT_SKIP;
    s0_basin  = '0;
    s0_addr   = AW'(in_data.basin_index);
    case (in_data.kind)
      KIND_ACCUM: begin
        s0_addr = AW'(idx);
        if (lbl_neg) begin
          s0_status = STAT_SKIP;
        end else if (acc_over) begin
          s0_status = STAT_OVER;
        end else begin
          s0_status = STAT_ACCUM;
          s0_basin  = idx[ZCS_BASIN_W-1:0];
        end
      end
      KIND_READOUT, KIND_CLEAR: begin
        s0_basin = in_data.basin_index;
        if (ix_over) begin
          s0_status = STAT_OVER;
        end else if (in_data.kind == KIND_READOUT) begin
          s0_status = STAT_READOUT;
        end else begin
          s0_status = STAT_CLEARED;
        end
      end
      default: s0_status = STAT_SKIP;
    endcase
  end

  zcs_ram #(
    .WIDTH(ZCS_ENTRY_W),
    .DEPTH(MAX_BASINS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(s0_addr),
    .rdata(ram_rdata)
  );

  // modify stage
  always_comb begin
    cur     = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : ram_rdata;
    cur_cnt = cur[ZCS_ENTRY_W-1:ZCS_SUM_W];
    cur_sum = cur[ZCS_SUM_W-1:0];
    new_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + 32'd1;
    new_sum = cur_sum + {{32{s1_value_r[31]}}, s1_value_r};
    s2_we   = 1'b0;
    s2_out.status       = s1_status_r;
    s2_out.result_basin = s1_basin_r;
    s2_out.cell_count   = '0;
    s2_out.value_sum    = '0;
    case (s1_status_r)
      STAT_ACCUM: begin
        s2_we = s1_valid_r;
        s2_out.cell_count = new_cnt;
        s2_out.value_sum  = new_sum;
      end
      STAT_READOUT: begin
        s2_out.cell_count = cur_cnt;
        s2_out.value_sum  = cur_sum;
      end
      STAT_CLEARED: s2_we = s1_valid_r;
      default: s2_we = 1'b0;
    endcase
  end

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s2_we;
      ram_waddr = s1_addr_r;
      ram_wdata = {s2_out.cell_count, s2_out.value_sum};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_basins_r <= '0;
      clearing_r   <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      fwd_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_basins_r <= cfg_wdata;
      end
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          clearing_r <= 1'b0;
        end
      end
      // drop unknown kinds at the door
      s1_valid_r  <= accept && (in_data.kind != KIND_UNUSED);
      fwd_valid_r <= s2_we;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_status_r <= s0_status;
    s1_basin_r  <= s0_basin;
    s1_addr_r   <= s0_addr;
    s1_value_r  <= in_data.cell_value;
    fwd_addr_r  <= s1_addr_r;
    fwd_data_r  <= ram_wdata;
    out_r       <= s2_out;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s1_valid_r && !out_valid_r)
    else $error("transaction in flight during clearing pass");

  a_result_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(s1_valid_r))
    else $error("result without a transaction in the read stage");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.status <= STAT_CLEARED)
    else $error("result status out of range");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == STAT_SKIP || out_r.status == STAT_OVER)
      |-> out_r.cell_count == '0 && out_r.value_sum == '0)
    else $error("skipped or flagged transaction carries data");

endmodule

[tb/sv/tb.sv]
module tb;
  import zcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_B = ZCS_MAX_BASINS_DEF;
  localparam int unsigned PHASE_RESULTS = 265;

  typedef struct {
    logic [ZCS_NB_W-1:0] nb;
    zcs_in_t             item;
    bit                  typed;
    zcs_out_t            want;
  } dir_row_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  zcs_in_t             in_data = '0;
  logic                out_valid;
  zcs_out_t            out_data;
  logic                cfg_we = 1'b0;
  logic [ZCS_NB_W-1:0] cfg_wdata = '0;

  // Own copy of the block's state
  logic [ZCS_NB_W-1:0]        basins_in_use = '0;
  logic [ZCS_CNT_W-1:0]       basin_cnt [MAX_B];
  logic signed [ZCS_SUM_W-1:0] basin_sum [MAX_B];

  zcs_out_t pending_stats [$];
  int       mismatches = 0;

  zonal_count_and_sum_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned basin_limit();
    return (basins_in_use < MAX_B) ? basins_in_use : MAX_B;
  endfunction

  // Apply one transaction to the stored statistics; return 0 where no result follows.
  function automatic bit zone_update(input zcs_in_t it, output zcs_out_t res);
    longint                 lbl;
    longint                 idx;
    int unsigned            lim;
    logic [ZCS_BASIN_W-1:0] b;
    lim = basin_limit();
    res = '0;
    case (it.kind)
      KIND_ACCUM: begin
        lbl = $signed(it.basin_label);
        idx = lbl / 2 - 1;
        if (idx < 0) begin
          res.status = STAT_SKIP;
        end else if (idx >= longint'(lim)) begin
          res.status = STAT_OVER;
        end else begin
          b = idx[ZCS_BASIN_W-1:0];
          if (basin_cnt[b] != 32'hFFFF_FFFF) basin_cnt[b] = basin_cnt[b] + 32'd1;
          basin_sum[b] = basin_sum[b] + longint'($signed(it.cell_value));
          res.status       = STAT_ACCUM;
          res.result_basin = b;
          res.cell_count   = basin_cnt[b];
          res.value_sum    = basin_sum[b];
        end
      end
      KIND_READOUT, KIND_CLEAR: begin
        b = it.basin_index;
        res.result_basin = it.basin_index;
        if (b >= lim) begin
          res.status = STAT_OVER;
        end else if (it.kind == KIND_READOUT) begin
          res.status     = STAT_READOUT;
          res.cell_count = basin_cnt[b];
          res.value_sum  = basin_sum[b];
        end else begin
          basin_cnt[b] = '0;
          basin_sum[b] = '0;
          res.status   = STAT_CLEARED;
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic dir_row_t mk_row(logic [ZCS_NB_W-1:0] nb, zcs_kind_t k, int lbl, int val,
                                      int idx, bit typed, zcs_status_t st, int rb, longint cnt,
                                      longint sum);
    dir_row_t row;
    row.nb                = nb;
    row.item.kind         = k;
    row.item.basin_label  = lbl;
    row.item.cell_value   = val;
    row.item.basin_index  = ZCS_BASIN_W'(idx);
    row.typed             = typed;
    row.want.status       = st;
    row.want.result_basin = ZCS_BASIN_W'(rb);
    row.want.cell_count   = cnt[31:0];
    row.want.value_sum    = sum;
    return row;
  endfunction

  // Favour a handful of low basins so that entries build up and back-to-back hits occur.
  function automatic int unsigned pick_basin(int unsigned lim);
    if (lim == 0) return $urandom_range(0, MAX_B - 1);
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, (lim < 8 ? lim : 8) - 1);
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic zcs_in_t draw_cell();
    zcs_in_t     it;
    int unsigned lim;
    int unsigned r;
    int unsigned v;
    lim = basin_limit();
    it.kind        = KIND_ACCUM;
    it.basin_label = $urandom();
    it.basin_index = ZCS_BASIN_W'($urandom());
    v = $urandom_range(0, 9);
    if (v < 5) it.cell_value = int'($urandom_range(0, 200)) - 100;
    else if (v < 8) it.cell_value = $urandom();
    else if (v == 8) it.cell_value = 32'sh7FFF_FFFF;
    else it.cell_value = 32'sh8000_0000;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      it.basin_label = 2 * (pick_basin(lim) + 1) + $urandom_range(0, 1);
    end else if (r < 60) begin
      it.basin_label = int'($urandom_range(0, 4)) - 3;
    end else if (r < 66) begin
      // keep the fully random label
    end else if (r < 70) begin
      it.basin_label = 2 * (lim + 1) + $urandom_range(0, 7);
    end else if (r < 82) begin
      it.kind = KIND_READOUT;
      if ($urandom_range(0, 3) != 0) it.basin_index = ZCS_BASIN_W'(pick_basin(lim));
    end else if (r < 92) begin
      it.kind = KIND_CLEAR;
      if ($urandom_range(0, 3) != 0) it.basin_index = ZCS_BASIN_W'(pick_basin(lim));
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  // Present one transaction and hold it until accepted; start stays high on return.
  task automatic feed_cell(input zcs_in_t it, input bit typed, input zcs_out_t want,
                           output bit gives);
    zcs_out_t calc;
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    gives = zone_update(it, calc);
    if (gives) pending_stats.push_back(typed ? want : calc);
  endtask

  // Drain, let a dropped transaction clear the pipeline, then write the register.
  task automatic set_basins(input logic [ZCS_NB_W-1:0] nb);
    start <= 1'b0;
    do @(posedge clk); while (pending_stats.size() != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= nb;
    @(posedge clk);
    cfg_we <= 1'b0;
    basins_in_use = nb;
  endtask

  always @(posedge clk) begin : result_check
    zcs_out_t want;
    if (rst_n && out_valid) begin
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d basin %0d count %0d sum %0d",
                   out_data.status, out_data.result_basin, out_data.cell_count,
                   $signed(out_data.value_sum));
      end else begin
        want = pending_stats.pop_front();
        if (out_data.status !== want.status || out_data.result_basin !== want.result_basin ||
            out_data.cell_count !== want.cell_count || out_data.value_sum !== want.value_sum)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     want.status, want.result_basin, want.cell_count,
                     $signed(want.value_sum), out_data.status, out_data.result_basin,
                     out_data.cell_count, $signed(out_data.value_sum));
        end
      end
    end
  end

  initial begin
    dir_row_t            rows [$];
    logic [ZCS_NB_W-1:0] phase_nb [6];
    bit                  gives;
    bit                  burst;
    int                  done;
    int                  gap;
    int unsigned         r;
    int                  k;

    foreach (basin_cnt[i]) begin
      basin_cnt[i] = '0;
      basin_sum[i] = '0;
    end

    // Reset value of the register: nothing is in range yet.
    rows.push_back(mk_row(13'd0, KIND_ACCUM, 4, 5, 0, 1, STAT_OVER, 0, 0, 0));
    rows.push_back(mk_row(13'd0, KIND_ACCUM, 1, 9, 0, 1, STAT_SKIP, 0, 0, 0));
    rows.push_back(mk_row(13'd0, KIND_READOUT, 0, 0, 0, 1, STAT_OVER, 0, 0, 0));
    rows.push_back(mk_row(13'd0, KIND_CLEAR, 0, 0, 4095, 1, STAT_OVER, 4095, 0, 0));
    rows.push_back(mk_row(13'd0, KIND_UNUSED, -1, -1, 4095, 0, STAT_ACCUM, 0, 0, 0));
    // Register above the store size: every basin in use.
    rows.push_back(mk_row(13'd8191, KIND_READOUT, 0, 0, 4095, 1, STAT_READOUT, 4095, 0, 0));
    rows.push_back(mk_row(13'd8191, KIND_ACCUM, 2, 32'sh7FFF_FFFF, 0, 1, STAT_ACCUM, 0, 1,
                          64'sd2147483647));
    rows.push_back(mk_row(13'd8191, KIND_ACCUM, 3, 32'sh8000_0000, 0, 1, STAT_ACCUM, 0, 2, -1));
    rows.push_back(mk_row(13'd8191, KIND_ACCUM, -1, 7, 0, 1, STAT_SKIP, 0, 0, 0));
    rows.push_back(mk_row(13'd8191, KIND_ACCUM, 32'sh8000_0000, 7, 0, 1, STAT_SKIP, 0, 0, 0));
    rows.push_back(mk_row(13'd8191, KIND_ACCUM, 0, 7, 0, 1, STAT_SKIP, 0, 0, 0));
    rows.push_back(mk_row(13'd8191, KIND_ACCUM, 32'sh7FFF_FFFF, 7, 4095, 1, STAT_OVER, 0, 0, 0));
    rows.push_back(mk_row(13'd8191, KIND_ACCUM, 8193, -1, 0, 1, STAT_ACCUM, 4095, 1, -1));
    rows.push_back(mk_row(13'd8191, KIND_ACCUM, 8194, 3, 0, 1, STAT_OVER, 0, 0, 0));
    rows.push_back(mk_row(13'd8191, KIND_READOUT, 0, 0, 4095, 1, STAT_READOUT, 4095, 1, -1));
    rows.push_back(mk_row(13'd8191, KIND_CLEAR, 0, 0, 4095, 1, STAT_CLEARED, 4095, 0, 0));
    rows.push_back(mk_row(13'd8191, KIND_READOUT, 0, 0, 4095, 1, STAT_READOUT, 4095, 0, 0));
    rows.push_back(mk_row(13'd8191, KIND_ACCUM, 2, 0, 0, 0, STAT_ACCUM, 0, 0, 0));
    rows.push_back(mk_row(13'd8191, KIND_READOUT, 0, 0, 0, 0, STAT_ACCUM, 0, 0, 0));
    rows.push_back(mk_row(13'd8191, KIND_CLEAR, 0, 0, 0, 1, STAT_CLEARED, 0, 0, 0));
    rows.push_back(mk_row(13'd8191, KIND_ACCUM, 4, 100, 0, 0, STAT_ACCUM, 0, 0, 0));
    // Smallest non-empty range.
    rows.push_back(mk_row(13'd1, KIND_ACCUM, 4, 5, 0, 1, STAT_OVER, 0, 0, 0));
    rows.push_back(mk_row(13'd1, KIND_READOUT, 0, 0, 1, 1, STAT_OVER, 1, 0, 0));
    rows.push_back(mk_row(13'd1, KIND_READOUT, 0, 0, 0, 0, STAT_ACCUM, 0, 0, 0));
    rows.push_back(mk_row(13'd1, KIND_ACCUM, 3, 7, 0, 0, STAT_ACCUM, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].nb != basins_in_use) set_basins(rows[i].nb);
      feed_cell(rows[i].item, rows[i].typed, rows[i].want, gives);
    end

    phase_nb = '{13'd4096, 13'd8, 13'd0, 13'd1, 13'd8191, 13'd2};
    phase_nb[5] = ZCS_NB_W'($urandom_range(2, 4095));

    foreach (phase_nb[p]) begin
      set_basins(phase_nb[p]);
      done  = 0;
      burst = 1'b0;
      while (done < PHASE_RESULTS) begin
        feed_cell(draw_cell(), 1'b0, '0, gives);
        if (gives) begin
          done++;
          if (done % 64 == 0) burst = ($urandom_range(0, 3) == 0);
        end
        gap = 0;
        if (!burst) begin
          r = $urandom_range(0, 99);
          if (r >= 94) gap = $urandom_range(8, 40);
          else if (r >= 65) gap = $urandom_range(1, 3);
        end
        if ($urandom_range(0, 149) == 0) begin
          // hold off until every outstanding result has come back
          start <= 1'b0;
          do @(posedge clk); while (pending_stats.size() != 0);
        end else if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    for (k = 0; k < 10000 && pending_stats.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
